>>> sv/hrv_pkg.sv
`default_nettype none

package hrv_pkg;

    localparam int RING_DEPTH = 60;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam int IVL_W  = 16;
    localparam int SUM_W  = IVL_W + CNT_W;
    localparam int SQ_W   = 2 * IVL_W + CNT_W;
    localparam int DQ_W   = SQ_W;
    localparam int DC_W   = $clog2(DQ_W);
    localparam int SQRT_W = SQ_W + (SQ_W % 2);
    localparam int ROOT_W = SQRT_W / 2;
    localparam int SC_W   = $clog2(ROOT_W);
    localparam int SREM_W = ROOT_W + 4;
    localparam int PNN_W  = CNT_W + 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NN50_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP      = 3'd6;

    localparam logic [15:0] RST_HIGH_THR   = 16'd50000;
    localparam logic [15:0] RST_LOW_THR    = 16'd40000;
    localparam logic [9:0]  RST_PERIOD     = 10'd40;
    localparam logic [15:0] RST_MIN_IVL    = 16'd400;
    localparam logic [15:0] RST_MAX_IVL    = 16'd2000;
    localparam logic [15:0] RST_NN50_LIMIT = 16'd50;

    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [6:0]  PCT_SCALE   = 7'd100;
    localparam int          MIN_REPORT  = 5;
    localparam logic [7:0]  SAT_8       = 8'd255;

endpackage

`default_nettype wire

>>> sv/hrv_ram.sv
`default_nettype none

module hrv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 60
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/pulse_peak_hrv_tracker.sv
// Pulse peak and HRV tracker.
// Input channel (i_valid / o_ready): i_mode 0 is an IR sample, 1 is a report
// request. Each input transfer yields exactly one result transfer on the
// output channel (o_valid / i_ready) carrying beat flag, stored interval,
// heart rate, RMSSD and pNN50.
// A sample that stores no beat, or any sample in sleep, goes straight to the
// output register. A stored beat walks the n stored intervals (an address
// and a data state each) to sum them, then runs the mean division on the
// shared restoring divider and, unless the mean is zero, the heart-rate
// division. A report walks the ring, squaring and summing the difference of
// each entry to the one before, then runs a division for the mean square, a
// square root and a division for pNN50. One item is in flight at a time;
// o_ready is high only while the sequencer is idle.
// A finished result sits in the output register; a stalled receiver holds
// the sequencer until the result register frees, then it returns to idle.
// Reset (synchronous, active low) restores the default thresholds, clears
// the clock, peak time, ring pointers and reported values. Ring contents
// are not cleared; only written entries are read. Config writes are taken
// on any cycle with i_cfg_we high; index 7 is ignored.
`default_nettype none

module pulse_peak_hrv_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hrv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hrv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_mode,
    input  wire logic [15:0]                    i_ir_sample,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_beat_stored,
    output logic      [15:0]                    o_interval_ms,
    output logic      [7:0]                     o_heart_rate_bpm,
    output logic      [7:0]                     o_rmssd_ms,
    output logic      [6:0]                     o_pnn50_pct
);

    localparam int IDX_W  = hrv_pkg::IDX_W;
    localparam int CNT_W  = hrv_pkg::CNT_W;
    localparam int DQ_W   = hrv_pkg::DQ_W;
    localparam int ROOT_W = hrv_pkg::ROOT_W;
    localparam int SQRT_W = hrv_pkg::SQRT_W;
    localparam int SREM_W = hrv_pkg::SREM_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RADDR = 4'd1;
    localparam logic [3:0] S_RDATA = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DIVE  = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_SQE   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [1:0] OP_MEAN = 2'd0;
    localparam logic [1:0] OP_HR   = 2'd1;
    localparam logic [1:0] OP_MSQ  = 2'd2;
    localparam logic [1:0] OP_PNN  = 2'd3;

    // configuration
    logic [15:0] r_high_thr, r_low_thr, r_min_ivl, r_max_ivl, r_nn50_lim;
    logic [9:0]  r_period;
    logic        r_sleep;

    // tracker state
    logic [3:0]       r_state;
    logic [IDX_W-1:0] r_widx;
    logic             r_full;
    logic             r_armed;
    logic [31:0]      r_clock_ms;
    logic [31:0]      r_last_peak;
    logic [7:0]       r_rate;
    logic [7:0]       r_rmssd;
    logic [6:0]       r_pnn;

    // sequencer working registers
    logic                     r_rep;
    logic                     r_first;
    logic [IDX_W-1:0]         r_addr;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         r_nn;
    logic [hrv_pkg::SUM_W-1:0] r_sum;
    logic [hrv_pkg::SQ_W-1:0]  r_sumsq;
    logic [15:0]              r_prev;
    logic [15:0]              r_diff;
    logic [31:0]              r_prod;
    logic                     r_beat;
    logic [15:0]              r_ivl;
    logic [1:0]               r_op;

    // shared divider
    logic [DQ_W-1:0]         r_dq;
    logic [15:0]             r_dvs;
    logic [15:0]             r_rem;
    logic [hrv_pkg::DC_W-1:0] r_dcnt;

    // square root
    logic [SQRT_W-1:0]        r_sq_v;
    logic [SREM_W-1:0]        r_sq_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [hrv_pkg::SC_W-1:0] r_scnt;

    logic r_ovalid;

    // ring
    logic        ram_we;
    logic [15:0] ram_rdata;

    // sample path
    logic [31:0]      n_clock;
    logic [31:0]      elapsed;
    logic             peak_hit;
    logic             take_peak;
    logic             do_store;
    logic [IDX_W-1:0] widx_inc;
    logic             n_full;
    logic [IDX_W-1:0] n_widx;
    logic [CNT_W-1:0] cnt_now;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] addr_inc;
    logic             accept;
    logic [15:0]      n_minus1;

    logic [16:0] d_trial;
    logic        d_ge;
    logic [16:0] d_sub;

    logic [SREM_W-1:0] s_rem2;
    logic [SREM_W-1:0] s_trial;
    logic              s_ge;

    logic [15:0] cur_diff;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    assign n_clock   = r_clock_ms + {22'd0, r_period};
    assign elapsed   = n_clock - r_last_peak;
    assign peak_hit  = (i_ir_sample > r_high_thr) && !r_armed;
    assign take_peak = peak_hit && (elapsed > {16'd0, r_min_ivl});
    assign do_store  = take_peak && (r_last_peak != 32'd0)
                       && (elapsed < {16'd0, r_max_ivl});

    assign widx_inc = (r_widx == IDX_W'(hrv_pkg::RING_DEPTH - 1)) ? '0 : r_widx + 1'b1;
    assign addr_inc = (r_addr == IDX_W'(hrv_pkg::RING_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign n_full   = r_full || (widx_inc == '0);
    assign n_widx   = widx_inc;
    assign cnt_now  = r_full ? CNT_W'(hrv_pkg::RING_DEPTH) : CNT_W'(r_widx);
    assign cnt_next = n_full ? CNT_W'(hrv_pkg::RING_DEPTH) : CNT_W'(n_widx);
    assign n_minus1 = 16'(r_n - 1'b1);

    assign ram_we = accept && !i_mode && !r_sleep && do_store;

    hrv_ram #(
        .WIDTH (16),
        .DEPTH (hrv_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (elapsed[15:0]),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign d_trial = {r_rem, r_dq[DQ_W-1]};
    assign d_ge    = d_trial >= {1'b0, r_dvs};
    assign d_sub   = d_trial - {1'b0, r_dvs};

    assign s_rem2  = {r_sq_rem[SREM_W-3:0], r_sq_v[SQRT_W-1 -: 2]};
    assign s_trial = {{(SREM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
    assign s_ge    = s_rem2 >= s_trial;

    assign cur_diff = (ram_rdata >= r_prev) ? ram_rdata - r_prev : r_prev - ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr  <= hrv_pkg::RST_HIGH_THR;
            r_low_thr   <= hrv_pkg::RST_LOW_THR;
            r_period    <= hrv_pkg::RST_PERIOD;
            r_min_ivl   <= hrv_pkg::RST_MIN_IVL;
            r_max_ivl   <= hrv_pkg::RST_MAX_IVL;
            r_nn50_lim  <= hrv_pkg::RST_NN50_LIMIT;
            r_sleep     <= 1'b0;
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_full      <= 1'b0;
            r_armed     <= 1'b0;
            r_clock_ms  <= '0;
            r_last_peak <= '0;
            r_rate      <= '0;
            r_rmssd     <= '0;
            r_pnn       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hrv_pkg::CFG_HIGH_THR:   r_high_thr <= i_cfg_data;
                    hrv_pkg::CFG_LOW_THR:    r_low_thr  <= i_cfg_data;
                    hrv_pkg::CFG_PERIOD:     r_period   <= i_cfg_data[9:0];
                    hrv_pkg::CFG_MIN_IVL:    r_min_ivl  <= i_cfg_data;
                    hrv_pkg::CFG_MAX_IVL:    r_max_ivl  <= i_cfg_data;
                    hrv_pkg::CFG_NN50_LIMIT: r_nn50_lim <= i_cfg_data;
                    hrv_pkg::CFG_SLEEP:      r_sleep    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // S_OUT owns r_ovalid while it loads a new result
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_beat <= 1'b0;
                        r_ivl  <= '0;
                        r_state <= S_OUT;
                        if (i_mode) begin
                            r_rep   <= 1'b1;
                            r_first <= 1'b1;
                            r_n     <= cnt_now;
                            r_k     <= '0;
                            r_nn    <= '0;
                            r_sumsq <= '0;
                            r_addr  <= r_full ? r_widx : '0;
                            if (cnt_now < CNT_W'(hrv_pkg::MIN_REPORT)) begin
                                r_rmssd <= '0;
                                r_pnn   <= '0;
                            end else begin
                                r_state <= S_RADDR;
                            end
                        end else if (!r_sleep) begin
                            r_clock_ms <= n_clock;
                            if (peak_hit) begin
                                r_armed <= 1'b1;
                                if (take_peak) begin
                                    r_last_peak <= n_clock;
                                end
                                if (do_store) begin
                                    r_widx  <= n_widx;
                                    r_full  <= n_full;
                                    r_beat  <= 1'b1;
                                    r_ivl   <= elapsed[15:0];
                                    r_rep   <= 1'b0;
                                    r_n     <= cnt_next;
                                    r_k     <= '0;
                                    r_sum   <= '0;
                                    r_addr  <= '0;
                                    r_state <= S_RADDR;
                                end
                            end else if (i_ir_sample < r_low_thr) begin
                                r_armed <= 1'b0;
                            end
                        end
                    end
                end
                S_RADDR: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_k    <= r_k + 1'b1;
                    r_addr <= addr_inc;
                    if (!r_rep) begin
                        r_sum <= r_sum + hrv_pkg::SUM_W'(ram_rdata);
                        if (r_k + 1'b1 == r_n) begin
                            r_dq    <= DQ_W'(r_sum + hrv_pkg::SUM_W'(ram_rdata));
                            r_dvs   <= 16'(r_n);
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_op    <= OP_MEAN;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_RADDR;
                        end
                    end else if (r_first) begin
                        r_first <= 1'b0;
                        r_prev  <= ram_rdata;
                        r_state <= S_RADDR;
                    end else begin
                        r_diff  <= cur_diff;
                        r_prev  <= ram_rdata;
                        if (cur_diff > r_nn50_lim) begin
                            r_nn <= r_nn + 1'b1;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_diff * r_diff;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sumsq <= r_sumsq + hrv_pkg::SQ_W'(r_prod);
                    if (r_k == r_n) begin
                        r_dq    <= DQ_W'(r_sumsq + hrv_pkg::SQ_W'(r_prod));
                        r_dvs   <= n_minus1;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_op    <= OP_MSQ;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_RADDR;
                    end
                end
                S_DIV: begin
                    r_rem  <= d_ge ? d_sub[15:0] : d_trial[15:0];
                    r_dq   <= {r_dq[DQ_W-2:0], d_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == hrv_pkg::DC_W'(DQ_W - 1)) begin
                        r_state <= S_DIVE;
                    end
                end
                S_DIVE: begin
                    case (r_op)
                        OP_MEAN: begin
                            if (r_dq == '0) begin
                                r_rate  <= hrv_pkg::SAT_8;
                                r_state <= S_OUT;
                            end else begin
                                r_dvs   <= r_dq[15:0];
                                r_dq    <= DQ_W'(hrv_pkg::MS_PER_MIN);
                                r_rem   <= '0;
                                r_dcnt  <= '0;
                                r_op    <= OP_HR;
                                r_state <= S_DIV;
                            end
                        end
                        OP_HR: begin
                            r_rate  <= (|r_dq[DQ_W-1:8]) ? hrv_pkg::SAT_8 : r_dq[7:0];
                            r_state <= S_OUT;
                        end
                        OP_MSQ: begin
                            r_sq_v   <= SQRT_W'(r_dq);
                            r_sq_rem <= '0;
                            r_root   <= '0;
                            r_scnt   <= '0;
                            r_state  <= S_SQRT;
                        end
                        OP_PNN: begin
                            r_pnn   <= r_dq[6:0];
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SQRT: begin
                    r_sq_rem <= s_ge ? s_rem2 - s_trial : s_rem2;
                    r_root   <= {r_root[ROOT_W-2:0], s_ge};
                    r_sq_v   <= {r_sq_v[SQRT_W-3:0], 2'b00};
                    r_scnt   <= r_scnt + 1'b1;
                    if (r_scnt == hrv_pkg::SC_W'(ROOT_W - 1)) begin
                        r_state <= S_SQE;
                    end
                end
                S_SQE: begin
                    r_rmssd <= (|r_root[ROOT_W-1:8]) ? hrv_pkg::SAT_8 : r_root[7:0];
                    r_dq    <= DQ_W'(hrv_pkg::PNN_W'(r_nn) * hrv_pkg::PNN_W'(hrv_pkg::PCT_SCALE));
                    r_dvs   <= n_minus1;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_op    <= OP_PNN;
                    r_state <= S_DIV;
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid         <= 1'b1;
                        o_beat_stored    <= r_beat;
                        o_interval_ms    <= r_ivl;
                        o_heart_rate_bpm <= r_rate;
                        o_rmssd_ms       <= r_rmssd;
                        o_pnn50_pct      <= r_pnn;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx < IDX_W'(hrv_pkg::RING_DEPTH))
        else $error("ring write index out of range");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("ring full flag dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready)
        else $error("sequencer idle right after a transfer");

    a_beat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_beat_stored) |-> (o_interval_ms != 16'd0))
        else $error("stored beat with zero interval");

    a_pnn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pnn <= 7'd100)
        else $error("pNN50 above 100");
`endif

endmodule

`default_nettype wire
